FILE: sv/mlfq_pkg.sv
// mlfq_pkg: shared constants, slot entry type and arithmetic helpers
// for the load and priority engine; no dependencies
package mlfq_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int PRI_TOP    = 63;
    localparam int PRI_BOTTOM = 0;
    localparam int FRAC_BITS  = 16;
    localparam int SLOT_W     = 6;
    localparam int DIV_W      = 41;
    localparam int DSR_W      = 25;

    localparam logic [28:0] DIV15_M = 29'd286331154;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_SEC   = 3'd1;
    localparam logic [2:0] REQ_NICE  = 3'd2;
    localparam logic [2:0] REQ_INIT  = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;
    localparam logic [2:0] REQ_REL   = 3'd5;

    typedef struct packed {
        logic signed [31:0] recent;
        logic signed [5:0]  nice;
        logic [5:0]         prio;
    } slot_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [5:0] clamp_pri(input logic signed [34:0] p);
        if (p < 35'(PRI_BOTTOM))
            return 6'(PRI_BOTTOM);
        else if (p > 35'(PRI_TOP))
            return 6'(PRI_TOP);
        else
            return p[5:0];
    endfunction

    function automatic logic signed [5:0] clamp_nice(input logic signed [5:0] n);
        if (n < -6'sd20)
            return -6'sd20;
        else if (n > 6'sd20)
            return 6'sd20;
        else
            return n;
    endfunction

    // floor(x/60) as floor(floor(x/4)/15), reciprocal multiply
    function automatic logic [31:0] div60(input logic [29:0] x);
        logic [56:0] p;
        p = 57'(x[29:2]) * 57'(DIV15_M);
        return {7'd0, p[56:32]};
    endfunction

    // floor(top - trunc(recent/4) - 2*nice) in fixed point, clamped
    function automatic logic [5:0] pri_calc(input logic signed [31:0] r,
                                            input logic signed [5:0] n);
        logic signed [34:0] q;
        logic signed [34:0] v;
        q = 35'(r);
        if (r < 0)
            q = q + 35'sd3;
        q = q >>> 2;
        v = (35'(PRI_TOP) <<< FRAC_BITS) - q - (35'(n) <<< (FRAC_BITS + 1));
        return clamp_pri(v >>> FRAC_BITS);
    endfunction

    // rounds a value already scaled by 100, half away from zero
    function automatic logic signed [31:0] round_x100(input logic signed [39:0] a);
        logic signed [40:0] t;
        t = 41'(a);
        if (t >= 0)
            t = (t + 41'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        else
            t = -(((-t) + 41'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
        return t[31:0];
    endfunction

endpackage

FILE: sv/mlfq_load_and_priority_engine.sv
// mlfq_load_and_priority_engine: top level, event sequencer around the slot store
// depends on mlfq_pkg, mlfq_div and mlfq_slot_ram
//
// Events enter on in_valid/in_ready, one at a time; results leave on
// out_valid/out_ready through one output register. in_ready is high only
// while the sequencer is idle, but a result may still sit in the output
// register when the next event is taken.
// Tick, set nice, init, query and release: one result, through the states
// S_MOD, S_X100 and S_OUT from the transfer to out_valid (read, modify and
// write back, scale by 100, round).
// Second update: the states S_D1S, S_D1W, S_D2S and S_D2W for the two load
// terms (divide by 60 by a reciprocal multiply), one pass through the
// bit-serial divider for the decay coefficient, then a walk over the valid
// slots other than the idle slot, each updated slot emitting a result; the
// walk ends after the last such slot, or with one result for thread_index if there is none.
// When the receiver stalls, the sequencer holds at the output stage and
// all state but the idle slot register holds. Reset clears the load
// average, all slot valid bits, the idle slot register and the output valid
// flag; the slot store is not cleared. The user must write idle_slot through
// cfg_we/cfg_wdata only while no event is pending; the block itself does not enforce it.
module mlfq_load_and_priority_engine
    import mlfq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [5:0]         thread_index,
    input  logic [6:0]         ready_count,
    input  logic signed [5:0]  nice_value,
    input  logic [5:0]         initial_priority,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         slot_index,
    output logic [5:0]         slot_priority,
    output logic [12:0]        load_avg_x100,
    output logic signed [31:0] recent_cpu_x100,
    output logic               last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_X100  = 4'd2;
    localparam logic [3:0] S_OUT   = 4'd3;
    localparam logic [3:0] S_D1S   = 4'd4;
    localparam logic [3:0] S_D1W   = 4'd5;
    localparam logic [3:0] S_D2S   = 4'd6;
    localparam logic [3:0] S_D2W   = 4'd7;
    localparam logic [3:0] S_D3S   = 4'd8;
    localparam logic [3:0] S_D3W   = 4'd9;
    localparam logic [3:0] S_WSCAN = 4'd10;
    localparam logic [3:0] S_WMUL  = 4'd11;
    localparam logic [3:0] S_WADD  = 4'd12;
    localparam logic [3:0] S_WPRI  = 4'd13;

    logic [3:0]               state_reg, state_next;
    logic [2:0]               req_reg, req_next;
    logic [SLOT_W-1:0]        s_reg, s_next;
    logic [6:0]               ready_reg, ready_next;
    logic signed [5:0]        nin_reg, nin_next;
    logic [5:0]               ipri_reg, ipri_next;
    logic [SLOT_W-1:0]        idle_reg, idle_next;
    logic [31:0]              load_reg, load_next;
    logic [31:0]              q1_reg, q1_next;
    logic [31:0]              q2_reg, q2_next;
    logic [15:0]              coef_reg, coef_next;
    logic [SLOT_W-1:0]        idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]     valid_reg, valid_next;
    logic                     walk_reg, walk_next;
    logic                     last_reg, last_next;
    logic [SLOT_W-1:0]        cslot_reg, cslot_next;
    logic                     cok_reg, cok_next;
    logic signed [31:0]       crecent_reg, crecent_next;
    logic signed [5:0]        cnice_reg, cnice_next;
    logic [5:0]               cprio_reg, cprio_next;
    logic signed [48:0]       prod_reg, prod_next;
    logic signed [39:0]       x100_reg, x100_next;
    logic [31:0]              lax_reg, lax_next;
    logic                     ovalid_reg, ovalid_next;
    logic [5:0]               oslot_reg, oslot_next;
    logic [5:0]               oprio_reg, oprio_next;
    logic [12:0]              oload_reg, oload_next;
    logic signed [31:0]       orecent_reg, orecent_next;
    logic                     olast_reg, olast_next;

    logic                     ram_we, ram_re;
    logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
    slot_t                    ram_wdata, ram_rdata;
    logic                     div_start, div_done;
    logic [DIV_W-1:0]         div_dividend, div_quotient;
    logic [DSR_W-1:0]         div_divisor;

    logic [NUM_SLOTS-1:0]     elig;
    logic                     beyond;
    logic                     vs;
    logic [7:0]               nready;
    logic signed [5:0]        nclamp;
    logic [31:0]              lround;

    mlfq_slot_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlfq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        elig   = valid_reg;
        elig[idle_reg] = 1'b0;
        beyond = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (elig[i] && (SLOT_W'(i) > idx_reg))
                beyond = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        s_next       = s_reg;
        ready_next   = ready_reg;
        nin_next     = nin_reg;
        ipri_next    = ipri_reg;
        idle_next    = cfg_we ? cfg_wdata : idle_reg;
        load_next    = load_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        coef_next    = coef_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        walk_next    = walk_reg;
        last_next    = last_reg;
        cslot_next   = cslot_reg;
        cok_next     = cok_reg;
        crecent_next = crecent_reg;
        cnice_next   = cnice_reg;
        cprio_next   = cprio_reg;
        prod_next    = prod_reg;
        x100_next    = x100_reg;
        lax_next     = lax_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        oslot_next   = oslot_reg;
        oprio_next   = oprio_reg;
        oload_next   = oload_reg;
        orecent_next = orecent_reg;
        olast_next   = olast_reg;

        ram_we       = 1'b0;
        ram_waddr    = s_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = s_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 25'd60;

        in_ready     = (state_reg == S_IDLE);
        vs           = valid_reg[s_reg];
        nready       = 8'(ready_reg) + ((s_reg != idle_reg) ? 8'd1 : 8'd0);
        nclamp       = clamp_nice(nin_reg);
        lround       = (lax_reg + 32'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    s_next     = thread_index;
                    ready_next = ready_count;
                    nin_next   = nice_value;
                    ipri_next  = initial_priority;
                    ram_re     = 1'b1;
                    ram_raddr  = thread_index;
                    case (req_type)
                        REQ_SEC:
                            state_next = S_D1S;
                        REQ_TICK, REQ_NICE, REQ_INIT, REQ_QUERY, REQ_REL:
                            state_next = S_MOD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                cslot_next   = s_reg;
                cok_next     = vs;
                crecent_next = ram_rdata.recent;
                cprio_next   = ram_rdata.prio;
                walk_next    = 1'b0;
                last_next    = 1'b1;
                ram_wdata    = ram_rdata;
                case (req_reg)
                    REQ_TICK:
                    begin
                        if (vs && s_reg != idle_reg)
                        begin
                            ram_wdata.recent = sat32(34'(ram_rdata.recent)
                                                     + 34'(1 << FRAC_BITS));
                            ram_we       = 1'b1;
                            crecent_next = ram_wdata.recent;
                        end
                    end
                    REQ_NICE:
                    begin
                        if (vs)
                        begin
                            ram_wdata.nice = nclamp;
                            if (s_reg != idle_reg)
                                ram_wdata.prio = pri_calc(ram_rdata.recent, nclamp);
                            ram_we     = 1'b1;
                            cprio_next = ram_wdata.prio;
                        end
                    end
                    REQ_INIT:
                    begin
                        ram_wdata.recent = '0;
                        ram_wdata.nice   = '0;
                        ram_wdata.prio   = clamp_pri(35'(ipri_reg));
                        ram_we           = 1'b1;
                        valid_next[s_reg] = 1'b1;
                        cok_next         = 1'b1;
                        crecent_next     = '0;
                        cprio_next       = ram_wdata.prio;
                    end
                    REQ_REL:
                    begin
                        valid_next[s_reg] = 1'b0;
                        cok_next          = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_X100;
            end
            S_X100:
            begin
                x100_next  = 40'(crecent_reg) * 40'sd100;
                lax_next   = load_reg * 32'd100;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next  = 1'b1;
                    oslot_next   = cslot_reg;
                    oprio_next   = cok_reg ? cprio_reg : 6'd0;
                    orecent_next = cok_reg ? round_x100(x100_reg) : 32'sd0;
                    oload_next   = (lround > 32'd8191) ? 13'd8191 : lround[12:0];
                    olast_next   = last_reg;
                    if (walk_reg && !last_reg)
                    begin
                        idx_next   = idx_reg + SLOT_W'(1);
                        state_next = S_WSCAN;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_D1S:
            begin
                q1_next    = load_reg * 32'd59;
                state_next = S_D1W;
            end
            S_D1W:
            begin
                q1_next    = div60(q1_reg[29:0]);
                state_next = S_D2S;
            end
            S_D2S:
            begin
                q2_next    = div60(30'(nready) << FRAC_BITS);
                state_next = S_D2W;
            end
            S_D2W:
            begin
                load_next  = q1_reg + q2_reg;
                state_next = S_D3S;
            end
            S_D3S:
            begin
                div_start    = 1'b1;
                div_dividend = 41'(load_reg) << (FRAC_BITS + 1);
                div_divisor  = (25'(load_reg) << 1) + 25'(1 << FRAC_BITS);
                state_next   = S_D3W;
            end
            S_D3W:
            begin
                if (div_done)
                begin
                    coef_next  = div_quotient[15:0];
                    idx_next   = '0;
                    walk_next  = 1'b1;
                    state_next = S_WSCAN;
                end
            end
            S_WSCAN:
            begin
                if (elig[idx_reg])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg;
                    state_next = S_WMUL;
                end
                else if (idx_reg == SLOT_W'(NUM_SLOTS - 1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = s_reg;
                    state_next = S_MOD;
                end
                else
                    idx_next = idx_reg + SLOT_W'(1);
            end
            S_WMUL:
            begin
                prod_next  = 49'($signed({1'b0, coef_reg}) * ram_rdata.recent);
                cnice_next = ram_rdata.nice;
                state_next = S_WADD;
            end
            S_WADD:
            begin
                crecent_next = sat32(34'(prod_reg >>> FRAC_BITS)
                                     + (34'(cnice_reg) <<< FRAC_BITS));
                state_next   = S_WPRI;
            end
            S_WPRI:
            begin
                cprio_next       = pri_calc(crecent_reg, cnice_reg);
                ram_we           = 1'b1;
                ram_waddr        = idx_reg;
                ram_wdata.recent = crecent_reg;
                ram_wdata.nice   = cnice_reg;
                ram_wdata.prio   = cprio_next;
                cslot_next       = idx_reg;
                cok_next         = 1'b1;
                last_next        = !beyond;
                state_next       = S_X100;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idle_reg   <= '0;
            load_reg   <= '0;
            valid_reg  <= '0;
            walk_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idle_reg   <= idle_next;
            load_reg   <= load_next;
            valid_reg  <= valid_next;
            walk_reg   <= walk_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        s_reg       <= s_next;
        ready_reg   <= ready_next;
        nin_reg     <= nin_next;
        ipri_reg    <= ipri_next;
        q1_reg      <= q1_next;
        q2_reg      <= q2_next;
        coef_reg    <= coef_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        cslot_reg   <= cslot_next;
        cok_reg     <= cok_next;
        crecent_reg <= crecent_next;
        cnice_reg   <= cnice_next;
        cprio_reg   <= cprio_next;
        prod_reg    <= prod_next;
        x100_reg    <= x100_next;
        lax_reg     <= lax_next;
        oslot_reg   <= oslot_next;
        oprio_reg   <= oprio_next;
        oload_reg   <= oload_next;
        orecent_reg <= orecent_next;
        olast_reg   <= olast_next;
    end

    assign out_valid       = ovalid_reg;
    assign slot_index      = oslot_reg;
    assign slot_priority   = oprio_reg;
    assign load_avg_x100   = oload_reg;
    assign recent_cpu_x100 = orecent_reg;
    assign last            = olast_reg;

endmodule

FILE: sv/mlfq_div.sv
// mlfq_div: restoring divider, one quotient bit per cycle
// depends on mlfq_pkg for operand widths
module mlfq_div
    import mlfq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W:0]   rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   trial;
    logic             ge;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[DSR_W-1:0], quo_reg[DIV_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial - {1'b0, dsr_reg} : trial;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/mlfq_slot_ram.sv
// mlfq_slot_ram: per-slot recent cpu, nice and priority store
// one write and one registered read port; depends on mlfq_pkg
module mlfq_slot_ram
    import mlfq_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  slot_t             wdata,
    input  logic              re,
    input  logic [SLOT_W-1:0] raddr,
    output slot_t             rdata
);

    slot_t mem [NUM_SLOTS];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
